@@ sv/ffba_pkg.sv @@
`default_nettype none

package ffba_pkg;

    // Bytes of block header ahead of every user area
    localparam int unsigned HEADER_BYTES = 24;

    localparam int unsigned SIZE_W = 24;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned CFG_IDX_W = 2;

    // Request operation codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NULL      = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_code_t;

    // Source of the returned user address
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_HIT,
        RES_APPEND
    } res_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic         start;      // latch request, rewind scan
        logic         scan;       // issue next table read
        logic         hit_wr;     // rewrite the matching entry
        logic         append_wr;  // append an entry at the break
        logic         load_res;   // load the result register
        res_sel_t     res_sel;
        status_code_t res_status;
    } ffba_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_free;
        logic req_null;
        logic hit;
        logic scan_end;
        logic table_full;
        logic heap_over;
    } ffba_stat_t;

endpackage

`default_nettype wire

@@ sv/ffba_datapath.sv @@
`default_nettype none

module ffba_datapath
    import ffba_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ffba_cmd_t            cmd,
    output ffba_stat_t                stat,
    input  wire logic                 req_cmd,
    input  wire logic [SIZE_W-1:0]    req_size,
    input  wire logic [ADDR_W-1:0]    req_addr,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data,
    output logic [ADDR_W-1:0]         res_addr,
    output logic [2:0]                res_status
);

    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned EW = 1 + SIZE_W + ADDR_W;

    // Table entry: used flag, user size, block base
    logic [EW-1:0] tbl_mem [MAX_BLOCKS];

    logic                 req_cmd_reg;
    logic [SIZE_W-1:0]    req_size_reg;
    logic [ADDR_W-1:0]    req_addr_reg;
    logic [CW-1:0]        rd_ptr_reg;
    logic                 pend_reg;
    logic [AW-1:0]        eval_idx_reg;
    logic [EW-1:0]        rd_data_reg;
    logic [CW-1:0]        count_reg;
    logic [ADDR_W-1:0]    break_reg;
    logic [ADDR_W-1:0]    limit_reg;
    logic [ADDR_W-1:0]    res_addr_reg;
    logic [2:0]           res_status_reg;
    logic [ADDR_W-1:0]    res_addr_next;

    logic                 rd_used;
    logic [SIZE_W-1:0]    rd_size;
    logic [ADDR_W-1:0]    rd_base;
    logic [ADDR_W-1:0]    rd_user;
    logic [ADDR_W:0]      new_end;
    logic                 more;
    logic                 wr_en;
    logic [AW-1:0]        wr_idx;
    logic [EW-1:0]        wr_data;

    assign rd_used = rd_data_reg[EW-1];
    assign rd_size = rd_data_reg[SIZE_W+ADDR_W-1:ADDR_W];
    assign rd_base = rd_data_reg[ADDR_W-1:0];
    assign rd_user = rd_base + ADDR_W'(HEADER_BYTES);

    assign new_end = {1'b0, break_reg} + (ADDR_W+1)'(HEADER_BYTES)
                   + {{(ADDR_W+1-SIZE_W){1'b0}}, req_size_reg};
    assign more    = (rd_ptr_reg < count_reg);

    // Status towards the controller
    always_comb begin
        stat.is_free    = (req_cmd_reg == CMD_FREE);
        stat.req_null   = (req_cmd_reg == CMD_FREE) ? (req_addr_reg == '0)
                                                    : (req_size_reg == '0);
        stat.hit        = pend_reg && ((req_cmd_reg == CMD_FREE)
                        ? (rd_user == req_addr_reg)
                        : (!rd_used && (rd_size >= req_size_reg)));
        stat.scan_end   = !pend_reg && !more;
        stat.table_full = (count_reg == CW'(MAX_BLOCKS));
        stat.heap_over  = (new_end > {1'b0, limit_reg});
    end

    // Table write: rewrite a match or append at the break
    always_comb begin
        wr_en   = cmd.hit_wr || cmd.append_wr;
        wr_idx  = cmd.hit_wr ? eval_idx_reg : count_reg[AW-1:0];
        wr_data = cmd.hit_wr ? {(req_cmd_reg == CMD_ALLOC), rd_size, rd_base}
                             : {1'b1, req_size_reg, break_reg};
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tbl_mem[wr_idx] <= wr_data;
        end
        if (cmd.scan && more) begin
            rd_data_reg <= tbl_mem[rd_ptr_reg[AW-1:0]];
        end
    end

    // Latch request payload
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            req_cmd_reg  <= req_cmd;
            req_size_reg <= req_size;
            req_addr_reg <= req_addr;
        end
    end

    // Scan pointers: read address runs one ahead of evaluation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            pend_reg   <= 1'b0;
        end else if (cmd.start) begin
            rd_ptr_reg <= '0;
            pend_reg   <= 1'b0;
        end else if (cmd.scan) begin
            pend_reg <= more;
            if (more) begin
                rd_ptr_reg   <= rd_ptr_reg + CW'(1);
                eval_idx_reg <= rd_ptr_reg[AW-1:0];
            end
        end
    end

    // Heap state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            break_reg <= '0;
            limit_reg <= '1;
        end else begin
            if (cfg_we && (cfg_index == CFG_HEAP_BASE)) begin
                if (count_reg == '0) begin
                    break_reg <= cfg_data;
                end
            end
            if (cfg_we && (cfg_index == CFG_HEAP_LIMIT)) begin
                limit_reg <= cfg_data;
            end
            if (cmd.append_wr) begin
                count_reg <= count_reg + CW'(1);
                break_reg <= new_end[ADDR_W-1:0];
            end
        end
    end

    // Result payload
    always_comb begin
        case (cmd.res_sel)
            RES_HIT:    res_addr_next = rd_user;
            RES_APPEND: res_addr_next = break_reg + ADDR_W'(HEADER_BYTES);
            default:    res_addr_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_res) begin
            res_addr_reg   <= res_addr_next;
            res_status_reg <= cmd.res_status;
        end
    end

    assign res_addr   = res_addr_reg;
    assign res_status = res_status_reg;

endmodule

`default_nettype wire

@@ sv/ffba_ctrl.sv @@
`default_nettype none

module ffba_ctrl
    import ffba_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire ffba_stat_t stat,
    output ffba_cmd_t       cmd
);

    typedef enum logic [1:0] {
        IDLE,
        START,
        SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == IDLE);
    assign m_valid  = m_valid_reg;

    // Sequence the request and choose the outcome
    always_comb begin
        state_next     = state_reg;
        cmd.start      = 1'b0;
        cmd.scan       = 1'b0;
        cmd.hit_wr     = 1'b0;
        cmd.append_wr  = 1'b0;
        cmd.load_res   = 1'b0;
        cmd.res_sel    = RES_ZERO;
        cmd.res_status = ST_OK;
        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = START;
                end
            end
            START: begin
                // hold until the result register is free
                if (out_free) begin
                    if (stat.req_null) begin
                        cmd.load_res   = 1'b1;
                        cmd.res_status = ST_NULL;
                        state_next     = IDLE;
                    end else begin
                        state_next = SCAN;
                    end
                end
            end
            SCAN: begin
                if (stat.hit) begin
                    cmd.hit_wr   = 1'b1;
                    cmd.load_res = 1'b1;
                    cmd.res_sel  = stat.is_free ? RES_ZERO : RES_HIT;
                    state_next   = IDLE;
                end else if (stat.scan_end) begin
                    cmd.load_res = 1'b1;
                    state_next   = IDLE;
                    if (stat.is_free) begin
                        cmd.res_status = ST_NOT_FOUND;
                    end else if (stat.table_full) begin
                        cmd.res_status = ST_FULL;
                    end else if (stat.heap_over) begin
                        cmd.res_status = ST_EXHAUSTED;
                    end else begin
                        cmd.append_wr = 1'b1;
                        cmd.res_sel   = RES_APPEND;
                    end
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.load_res) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/first_fit_block_allocator.sv @@
// A null request gives its result without a table scan; any other request is settled by
// the table scan, which reads one entry per cycle.
// One transaction at a time; the next is accepted the cycle after the result is loaded.
// Reset (aresetn, synchronous, active low): empty table, heap_base 0, heap_limit all ones,
// break at 0, no result pending. Table contents are not cleared.
`default_nettype none

module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_cmd,
    input  wire logic [SIZE_W-1:0]    s_req_size,
    input  wire logic [ADDR_W-1:0]    s_user_addr_in,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [ADDR_W-1:0]         m_user_addr_out,
    output logic [2:0]                m_status,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data
);

    ffba_cmd_t  cmd;
    ffba_stat_t stat;

    ffba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ffba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .req_cmd    (s_cmd),
        .req_size   (s_req_size),
        .req_addr   (s_user_addr_in),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res_addr   (m_user_addr_out),
        .res_status (m_status)
    );

endmodule

`default_nettype wire
